>>> hdl/cis_pkg.sv
// cis_pkg: shared widths, field positions and register indexes for the
// constant immediate splitter. No dependencies.
`default_nettype none

package cis_pkg;

  localparam int VALUE_W      = 64;
  localparam int REG_W        = 4;
  localparam int WORD_W       = 32;
  localparam int OPC_W        = 8;
  localparam int POS_W        = 6;
  localparam int IMM_BITS_DEF = 10;

  // bit positions inside an instruction word
  localparam int OPC_LSB   = 24;
  localparam int IMM_LSB   = 14;
  localparam int SHIFT_LSB = 8;

  // input tdata: value, dest_reg, padded to whole bytes
  localparam int IN_W  = VALUE_W + REG_W;
  localparam int IN_TW = ((IN_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD_OPCODE = 1'b0,
    CFG_XOR_OPCODE  = 1'b1
  } cfg_idx_t;

  localparam logic [OPC_W-1:0] LOAD_OPC_RST = 8'h00;
  localparam logic [OPC_W-1:0] XOR_OPC_RST  = 8'h01;

endpackage

`default_nettype wire

>>> hdl/constant_immediate_splitter_top.sv
// constant_immediate_splitter_top: splits a 64-bit constant into a run of
// load/xor immediate instruction words with one shared 64-bit shifter.
// Depends on cis_pkg.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: value, dest_reg
//  m_*      | out | m_tvalid/m_tready  | m_tdata: instr_word; m_tlast: last
//  cfg_*    | in  | cfg_we             | cfg_index, cfg_wdata
//
// Each word goes through the steps find low bit, right shift, left shift and
// output, the two shifts through the one shifter, and the output waits for
// m_tready. An item has n words, n <= ceil(64/IMM_BITS). s_tready is high
// only while idle.
// Reset (rst, synchronous) sets load_opcode to 0, xor_opcode to 1, idle.
`default_nettype none

module constant_immediate_splitter_top
  import cis_pkg::*;
#(
  parameter int IMM_BITS = IMM_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [OPC_W-1:0]     cfg_wdata,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_TW-1:0]     s_tdata,   // [63:0] value, [67:64] dest_reg, rest zero
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [WORD_W-1:0]         m_tdata,   // [31:0] instr_word
  output logic                      m_tlast    // last
);

  localparam int MAX_WORDS = (VALUE_W + IMM_BITS - 1) / IMM_BITS;
  localparam int K_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [K_W-1:0] K_LAST = K_W'(MAX_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHR,
    ST_SHL,
    ST_OUT
  } state_t;

  state_t               state;
  logic [VALUE_W-1:0]   v;
  logic [VALUE_W-1:0]   sh;
  logic [POS_W-1:0]     pos;
  logic [REG_W-1:0]     dreg;
  logic [K_W-1:0]       k;
  logic [OPC_W-1:0]     load_opcode;
  logic [OPC_W-1:0]     xor_opcode;
  logic [WORD_W-1:0]    word;
  logic                 last;
  logic                 run_end;

  // lowest set bit position, 63 for zero
  function automatic logic [POS_W-1:0] low_bit(input logic [VALUE_W-1:0] x);
    logic [VALUE_W-1:0] iso;
    logic [POS_W-1:0]   p;
    iso = x & (~x + VALUE_W'(1));
    p   = '0;
    for (int j = 0; j < VALUE_W; j++) begin
      if (iso[j]) p = p | POS_W'(j);
    end
    if (x == '0) p = POS_W'(VALUE_W - 1);
    return p;
  endfunction

  // shared shifter: arithmetic right for extraction, left to put back
  logic               shl;
  logic [VALUE_W-1:0] shift_in;
  logic [VALUE_W-1:0] shift_out;
  logic [VALUE_W-1:0] f_ext;
  logic [OPC_W-1:0]   opcode;
  logic [WORD_W-1:0]  word_next;

  assign f_ext = {{(VALUE_W - IMM_BITS){sh[IMM_BITS-1]}}, sh[IMM_BITS-1:0]};

  always_comb begin
    shl      = (state == ST_SHL);
    shift_in = shl ? (sh ^ f_ext) : v;
    if (shl) begin
      shift_out = shift_in << pos;
    end else begin
      shift_out = unsigned'($signed(shift_in) >>> pos);
    end
  end

  assign opcode    = (k == '0) ? load_opcode : xor_opcode;
  assign word_next = (WORD_W'(opcode) << OPC_LSB)
                   | (WORD_W'(sh[IMM_BITS-1:0]) << IMM_LSB)
                   | (WORD_W'(pos) << SHIFT_LSB)
                   | WORD_W'(dreg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      load_opcode <= LOAD_OPC_RST;
      xor_opcode  <= XOR_OPC_RST;
      k           <= '0;
      run_end     <= 1'b0;
      last        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LOAD_OPCODE: load_opcode <= cfg_wdata;
          CFG_XOR_OPCODE:  xor_opcode  <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            v     <= s_tdata[VALUE_W-1:0];
            dreg  <= s_tdata[VALUE_W +: REG_W];
            k     <= '0;
            state <= ST_FIND;
          end
        end
        ST_FIND: begin
          pos   <= low_bit(v);
          state <= ST_SHR;
        end
        ST_SHR: begin
          sh    <= shift_out;
          state <= ST_SHL;
        end
        ST_SHL: begin
          v       <= shift_out;
          word    <= word_next;
          last    <= (shift_out == '0);
          run_end <= (shift_out == '0) || (k == K_LAST);
          state   <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            k     <= k + K_W'(1);
            state <= run_end ? ST_IDLE : ST_FIND;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = word;
  assign m_tlast  = last;

`ifndef SYNTHESIS
  // one item at a time: never ready for input while a word is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // a word flagged last leaves nothing of the constant behind
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (v == '0))
    else $error("last word with residue left");

  // after the last transaction of a run the block is idle again
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after last word");

  // run never passes its word limit
  a_word_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (k <= K_LAST))
    else $error("word count past limit");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for constant_immediate_splitter_top. Directed and random
// constants go through a stream driver; a monitor checks each instruction word against
// an internal splitter predictor. Depends on cis_pkg and the top-level RTL.
`default_nettype none

module tb_top;
  import cis_pkg::*;

  localparam int IMM       = IMM_BITS_DEF;
  localparam int MAX_WORDS = (VALUE_W + IMM - 1) / IMM;
  localparam int LIMIT     = 400000;
  localparam int IDLE_PCT  = 16;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [REG_W-1:0]   dreg;
  } const_item_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } instr_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OPC_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_TW-1:0]     s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_W-1:0]    m_tdata;
  logic                 m_tlast;

  const_item_t  pending_consts[$];
  instr_t       expected_words[$];
  logic [OPC_W-1:0] load_opc = LOAD_OPC_RST;
  logic [OPC_W-1:0] xor_opc  = XOR_OPC_RST;
  logic         no_idle = 1'b0;
  int           errors = 0;
  int           cycles = 0;
  const_item_t  next_item;
  instr_t       got_word;
  instr_t       want_word;

  constant_immediate_splitter_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Peel signed IMM-wide fields off the constant, lowest set bit first.
  function automatic void split_constant(logic [VALUE_W-1:0] value, logic [REG_W-1:0] dreg);
    logic signed [VALUE_W-1:0] rem;
    logic [VALUE_W-1:0] shv;
    logic [IMM-1:0]     fld;
    logic [VALUE_W-1:0] fext;
    logic [OPC_W-1:0]   opc;
    int                 pos;
    int                 k;
    instr_t             w;
    rem = value;
    k = 0;
    do begin
      pos = 63;
      for (int b = 63; b >= 0; b--)
        if (rem[b]) pos = b;
      shv  = rem >>> pos;   // bits above 63 read as the sign
      fld  = shv[IMM-1:0];
      fext = {{(VALUE_W-IMM){fld[IMM-1]}}, fld};
      rem  = rem ^ (fext << pos);
      opc  = (k == 0) ? load_opc : xor_opc;
      w.word = (WORD_W'(opc) << OPC_LSB) | (WORD_W'(fld) << IMM_LSB) |
               (WORD_W'(pos) << SHIFT_LSB) | WORD_W'(dreg);
      w.last = (rem == 0);
      expected_words.push_back(w);
      k++;
    end while (rem != 0 && k < MAX_WORDS);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_constant();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = {{48{1'b0}}, 16'($urandom)} ^ {64{$urandom_range(1) == 1}};
      2: begin
        v = '0;
        repeat ($urandom_range(1, 4)) v[$urandom_range(63)] = 1'b1;
      end
      3: v = {$urandom, $urandom} << $urandom_range(50, 63);
      4: v = {{32{1'b0}}, $urandom} ^ {64{$urandom_range(1) == 1}};
      default: v = {$urandom, $urandom} & ({64{1'b1}} << $urandom_range(63));
    endcase
    return v;
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        split_constant(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: REG_W]);
      if (!s_tvalid || s_tready) begin
        if (pending_consts.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          next_item = pending_consts.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TW'({next_item.dreg, next_item.value});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || $urandom_range(99) >= IDLE_PCT;
      if (m_tvalid && m_tready) begin
        got_word.word = m_tdata;
        got_word.last = m_tlast;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction word=%h last=%b", $time, m_tdata, m_tlast);
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.word !== want_word.word) begin
            errors++;
            $display("%0t: instr_word expected %h actual %h", $time, want_word.word,
                     got_word.word);
          end
          if (got_word.last !== want_word.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want_word.last, got_word.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("constant_immediate_splitter_top regression: fail");
      $finish;
    end
  end

  task automatic write_cfg(cfg_idx_t idx, logic [OPC_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_LOAD_OPCODE) load_opc = data;
    else xor_opc = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_consts.size() > 0 || s_tvalid || expected_words.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    const_item_t it;
    repeat (count) begin
      it.value = rand_constant();
      it.dreg  = REG_W'($urandom_range(15));
      pending_consts.push_back(it);
    end
  endtask

  task automatic queue_const(logic [VALUE_W-1:0] value, logic [REG_W-1:0] dreg);
    const_item_t it;
    it.value = value;
    it.dreg  = dreg;
    pending_consts.push_back(it);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset opcodes, extremes, high shift positions, longest runs
    queue_const(64'h0, 4'd0);
    queue_const(64'hffff_ffff_ffff_ffff, 4'd15);
    queue_const(64'h1, 4'd1);
    queue_const(64'h7fff_ffff_ffff_ffff, 4'd2);
    queue_const(64'h8000_0000_0000_0000, 4'd3);
    queue_const(64'h8000_0000_0000_0001, 4'd4);
    queue_const(64'h5555_5555_5555_5555, 4'd5);
    queue_const(64'haaaa_aaaa_aaaa_aaaa, 4'd6);
    queue_const(64'h0040_0000_0000_0000, 4'd7);
    queue_const(64'h0080_0000_0000_0000, 4'd8);
    queue_const(64'h0180_0000_0000_0000, 4'd9);
    queue_const(64'h4000_0000_0000_0000, 4'd10);
    queue_const(64'hc000_0000_0000_0000, 4'd11);
    queue_const(64'h7fc0_0000_0000_0000, 4'd12);
    queue_const(64'h0000_0000_0000_01ff, 4'd13);
    queue_const(64'h0000_0000_0000_0200, 4'd14);
    queue_const(64'hffff_ffff_ffff_fe00, 4'd15);
    queue_const(64'h1234_5678_9abc_def0, 4'd0);
    queue_const(64'hedcb_a987_6543_2101, 4'd15);
    queue_const(64'h0000_0001_0000_0000, 4'd7);
    drain();

    write_cfg(CFG_LOAD_OPCODE, 8'hff);
    write_cfg(CFG_XOR_OPCODE, 8'h00);
    no_idle = 1'b1;   // back-to-back stretch
    queue_random(100);
    drain();
    no_idle = 1'b0;

    write_cfg(CFG_LOAD_OPCODE, 8'h00);
    write_cfg(CFG_XOR_OPCODE, 8'hff);
    queue_random(100);
    drain();

    write_cfg(CFG_LOAD_OPCODE, OPC_W'($urandom_range(255)));
    write_cfg(CFG_XOR_OPCODE, OPC_W'($urandom_range(255)));
    queue_random(100);
    drain();

    write_cfg(CFG_XOR_OPCODE, 8'h5a);
    write_cfg(CFG_LOAD_OPCODE, 8'ha5);
    queue_random(100);
    drain();
    repeat (30) @(posedge clk);

    if (errors == 0 && expected_words.size() == 0)
      $display("constant_immediate_splitter_top regression: pass");
    else
      $display("constant_immediate_splitter_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hdl/cis_pkg.sv
hdl/constant_immediate_splitter_top.sv
bench/tb_top.sv
